// ----- rtl/scalar_kalman_filter_core_defines.svh -----
// ----------------------------------------------------------------------------
// scalar kalman filter core assertion macros
// concurrent check macros, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define SKF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skf check failed");
// next-cycle implication, disabled in reset
`define SKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skf check failed");
`else
`define SKF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SKF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// widths, constants and shared types of the scalar kalman filter
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int EST_W   = 32;          // Q16.16 estimate / measurement
  localparam int COV_W   = 24;          // Q8.16 covariance and noise values
  localparam int DEN_W   = COV_W + 1;   // covariance plus measurement noise
  localparam int GAIN_W  = 16;          // Q0.16 gain
  localparam int DIFF_W  = EST_W + 1;   // innovation
  localparam int MUL_A_W = GAIN_W + 1;  // gain or one minus gain
  localparam int MUL_B_W = DIFF_W + 1;  // signed operand
  localparam int MUL_P_W = MUL_A_W + 1 + MUL_B_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [COV_W-1:0]   COV_ONE   = 24'h01_0000;
  localparam logic [COV_W-1:0]   COV_MAX   = 24'hFF_FFFF;
  localparam logic [GAIN_W-1:0]  GAIN_MAX  = 16'hFFFF;
  localparam logic [MUL_A_W-1:0] GAIN_ONE  = 17'h1_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ESTIMATE  = 2'd2;

  localparam logic [COV_W-1:0] PROCESS_NOISE_RST     = 24'd1311;
  localparam logic [COV_W-1:0] MEASUREMENT_NOISE_RST = 24'd13107;
  localparam logic [EST_W-1:0] INITIAL_ESTIMATE_RST  = 32'd0;

  typedef struct packed {
    logic             start;
    logic [COV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } skf_div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] quotient;
  } skf_div_rsp_t;

endpackage

// ----- rtl/skf_ifs.sv -----
// ----------------------------------------------------------------------------
// skf channel interfaces
// valid/ready channels for measurement, estimate and register writes
// ----------------------------------------------------------------------------
interface skf_meas_if import skf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] measurement;
  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_est_if import skf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimate;
  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

interface skf_cfg_if import skf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/skf_divider.sv -----
// ----------------------------------------------------------------------------
// skf_divider
// restoring divider, one quotient bit per cycle, dividend below divisor
// ----------------------------------------------------------------------------
module skf_divider import skf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  skf_div_req_t req,
  output skf_div_rsp_t rsp
);

  localparam int STEPS = GAIN_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [GAIN_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    twice;
  logic              ge;

  // one compare and subtract per step
  assign twice = {rem_r, 1'b0};
  assign ge    = (twice >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = {1'b0, req.dividend};
      quo_nxt = '0;
      cnt_nxt = CNT_W'(STEPS);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? DEN_W'(twice - {1'b0, den_r}) : twice[DEN_W-1:0];
      quo_nxt  = {quo_r[GAIN_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) den_r <= req.divisor;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- rtl/skf_mult.sv -----
// ----------------------------------------------------------------------------
// skf_mult
// shared unsigned by signed multiplier with registered product
// ----------------------------------------------------------------------------
module skf_mult import skf_pkg::*; (
  input  logic                      clk,
  input  logic        [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod_r
);

  logic signed [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = $signed({1'b0, a}) * b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- rtl/scalar_kalman_filter_core.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// sequence: an accepted measurement word passes through ST_PRED, ST_DIVS,
//   ST_DIV (the 16-step gain divider, skipped when measurement_noise is zero),
//   ST_MUL1, ST_MUL2, ST_FIN and ST_WRITE; no new word is accepted before
//   ST_WRITE hands it on; a stalled consumer holds the next result
// the result sits in an output register while the next word is accepted
// reset: synchronous active-low rst_n; control registers take reset values,
// estimate loads the initial_estimate reset value, covariance returns to 1.0
// ----------------------------------------------------------------------------
// fixed-point one-dimensional kalman filter with one shared divider and one
// shared multiplier driven by a small sequencer
// ----------------------------------------------------------------------------
`include "scalar_kalman_filter_core_defines.svh"

module scalar_kalman_filter_core import skf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  skf_meas_if.sink   in_if,
  skf_est_if.source  out_if,
  skf_cfg_if.sink    cfg_if
);

  typedef enum logic [2:0] {
    ST_IDLE,   // ready for a measurement word
    ST_PRED,   // predicted covariance; the innovation is formed on acceptance
    ST_DIVS,   // launch divider, or take the gain directly when r is zero
    ST_DIV,    // wait for the serial divider
    ST_MUL1,   // multiplier: gain times innovation
    ST_MUL2,   // multiplier: (1 - gain) times covariance, take new estimate
    ST_FIN,    // take new covariance
    ST_WRITE   // hand the estimate to the output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [COV_W-1:0] q_r, q_nxt;
  logic [COV_W-1:0] r_r, r_nxt;
  logic [EST_W-1:0] init_r, init_nxt;

  // filter state
  logic signed [EST_W-1:0] x_r, x_nxt;
  logic [COV_W-1:0]        p_r, p_nxt;

  // per-word work registers
  logic [COV_W-1:0]         pp_r, pp_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic signed [DIFF_W-1:0] d_r, d_nxt;
  logic [GAIN_W-1:0]        k_r, k_nxt;
  logic signed [EST_W-1:0]  nx_r, nx_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [EST_W-1:0] out_est_r, out_est_nxt;

  // shared units
  skf_div_req_t              div_req;
  skf_div_rsp_t              div_rsp;
  logic        [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  // datapath helpers
  logic [DEN_W-1:0]          p_sum;
  logic signed [MUL_P_W-1:0] est_rnd;
  logic signed [MUL_P_W-1:0] est_shift;
  logic signed [EST_W+1:0]   est_sum;
  logic [MUL_A_W+COV_W-1:0]  cov_rnd;
  logic [DEN_W-1:0]          cov_new;

  logic in_acc, out_acc, cfg_acc;

  assign in_acc  = in_if.valid & in_if.ready;
  assign out_acc = out_if.valid & out_if.ready;
  assign cfg_acc = cfg_if.valid & cfg_if.ready;

  assign in_if.ready     = (state_r == ST_IDLE);
  assign cfg_if.ready    = 1'b1;
  assign out_if.valid    = out_valid_r;
  assign out_if.estimate = out_est_r;

  skf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  skf_mult u_mult (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_p)
  );

  // prediction: covariance plus process noise, saturated at the Q8.16 range
  assign p_sum = {1'b0, p_r} + {1'b0, q_r};

  // gain divider: pp / (pp + r), always a proper fraction when r is nonzero
  // the divisor is the denominator formed in the launch cycle
  assign div_req.start    = (state_r == ST_DIVS) && (r_r != '0);
  assign div_req.dividend = pp_r;
  assign div_req.divisor  = den_nxt;

  // multiplier operand select: first pass innovation, second pass covariance
  always_comb begin
    if (state_r == ST_MUL1) begin
      mul_a = {1'b0, k_r};
      mul_b = {d_r[DIFF_W-1], d_r};
    end else begin
      mul_a = GAIN_ONE - {1'b0, k_r};
      mul_b = $signed({{(MUL_B_W-COV_W){1'b0}}, pp_r});
    end
  end

  // estimate update: round half up, arithmetic shift is a floor
  assign est_rnd   = mul_p + MUL_P_W'(32768);
  assign est_shift = est_rnd >>> GAIN_W;
  assign est_sum   = {{2{x_r[EST_W-1]}}, x_r} + est_shift[EST_W+1:0];

  // covariance update: product is nonnegative here
  assign cov_rnd = mul_p[MUL_A_W+COV_W-1:0] + (MUL_A_W+COV_W)'(32768);
  assign cov_new = cov_rnd[MUL_A_W+COV_W-1:GAIN_W];

  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    init_nxt      = init_r;
    x_nxt         = x_r;
    p_nxt         = p_r;
    pp_nxt        = pp_r;
    den_nxt       = den_r;
    d_nxt         = d_r;
    k_nxt         = k_r;
    nx_nxt        = nx_r;
    out_valid_nxt = out_valid_r;
    out_est_nxt   = out_est_r;

    // the consumer takes the pending estimate
    if (out_acc) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          d_nxt     = {in_if.measurement[EST_W-1], in_if.measurement}
                      - {x_r[EST_W-1], x_r};
          state_nxt = ST_PRED;
        end
      end
      ST_PRED: begin
        pp_nxt    = p_sum[COV_W] ? COV_MAX : p_sum[COV_W-1:0];
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        den_nxt = {1'b0, pp_r} + {1'b0, r_r};
        if (r_r == '0) begin
          // gain of one saturates; zero denominator gives zero gain
          k_nxt     = (pp_r != '0) ? GAIN_MAX : '0;
          state_nxt = ST_MUL1;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          k_nxt     = div_rsp.quotient;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        if (est_sum[EST_W+1:EST_W-1] == 3'b000 || est_sum[EST_W+1:EST_W-1] == 3'b111) begin
          nx_nxt = est_sum[EST_W-1:0];
        end else begin
          nx_nxt = est_sum[EST_W+1] ? {1'b1, {(EST_W-1){1'b0}}}
                                    : {1'b0, {(EST_W-1){1'b1}}};
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        p_nxt     = cov_new[COV_W] ? COV_MAX : cov_new[COV_W-1:0];
        x_nxt     = nx_r;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        // hold until the output register is free
        if (!out_valid_r || out_acc) begin
          out_valid_nxt = 1'b1;
          out_est_nxt   = x_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register writes; initial_estimate also restarts the filter
    if (cfg_acc) begin
      case (cfg_if.index)
        CFG_PROCESS_NOISE:     q_nxt = cfg_if.data[COV_W-1:0];
        CFG_MEASUREMENT_NOISE: r_nxt = cfg_if.data[COV_W-1:0];
        CFG_INITIAL_ESTIMATE: begin
          init_nxt = cfg_if.data[EST_W-1:0];
          x_nxt    = cfg_if.data[EST_W-1:0];
          p_nxt    = COV_ONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      q_r         <= PROCESS_NOISE_RST;
      r_r         <= MEASUREMENT_NOISE_RST;
      init_r      <= INITIAL_ESTIMATE_RST;
      x_r         <= INITIAL_ESTIMATE_RST;
      p_r         <= COV_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      q_r         <= q_nxt;
      r_r         <= r_nxt;
      init_r      <= init_nxt;
      x_r         <= x_nxt;
      p_r         <= p_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pp_r      <= pp_nxt;
    den_r     <= den_nxt;
    d_r       <= d_nxt;
    k_r       <= k_nxt;
    nx_r      <= nx_nxt;
    out_est_r <= out_est_nxt;
  end

  // accepted word always starts the prediction step
  `SKF_ASSERT_NEXT(a_acc_to_pred, clk, rst_n, in_acc, state_r == ST_PRED)
  // divider finishes only while the sequencer waits for it
  `SKF_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_rsp.done, state_r == ST_DIV)
  // a pending estimate is never overwritten
  `SKF_ASSERT_NEXT(a_no_overwrite, clk, rst_n,
                   state_r == ST_WRITE && out_valid_r && !out_if.ready,
                   state_r == ST_WRITE)
  // initial_estimate is the value the filter restarts from
  `SKF_ASSERT_NEXT(a_init_load, clk, rst_n,
                   cfg_acc && cfg_if.index == CFG_INITIAL_ESTIMATE,
                   x_r == init_r && p_r == COV_ONE)

endmodule
